### rtl/core/matrix_multiply_assert.svh
// Assertion macros for the matrix multiply block.
// Each check is clocked on clk and held off while rst_n is low.
`ifndef MATRIX_MULTIPLY_ASSERT_SVH
`define MATRIX_MULTIPLY_ASSERT_SVH

`ifndef SYNTHESIS
`define MM_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define MM_ASSERT_IMPLY(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`else
`define MM_ASSERT_ALWAYS(lbl, cond, msg)
`define MM_ASSERT_IMPLY(lbl, pre, post, msg)
`endif

`endif

### rtl/core/mm_pkg.sv
package mm_pkg;

    localparam int MAX_DIM_DEF   = 8;
    localparam int FRAC_BITS_DEF = 16;

    localparam int ELEM_W    = 32;
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int DIM_REG_W = 4;
    localparam int OP_W      = 2;
    localparam int POS_W     = 3;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_A_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_A_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B_ROWS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B_COLS = 2'd3;

    typedef struct packed {
        logic clear;
        logic shift;
    } cell_ctl_t;

endpackage

### rtl/core/matrix_multiply.sv
// Load items (op 0 and 1) are taken one per cycle while idle and cause no result.
// A compute item feeds one product per cycle into a chain of MAX_DIM accumulator
// cells, then the row is shifted out. A status-only result is registered in state
// S_STAT once the output register is free.
// Reset sets all dimensions to 1, clears the load counters, and marks every store
// word unwritten so that it reads as zero; no clearing pass is needed.
`include "matrix_multiply_assert.svh"

module matrix_multiply #(
    parameter int MAX_DIM   = mm_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = mm_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [mm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mm_pkg::DIM_REG_W-1:0] cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [mm_pkg::OP_W-1:0]      op,
    input  logic signed [mm_pkg::ELEM_W-1:0] value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [mm_pkg::ELEM_W-1:0] product,
    output logic [mm_pkg::POS_W-1:0]     row_index,
    output logic [mm_pkg::POS_W-1:0]     col_index,
    output logic [mm_pkg::STATUS_W-1:0]  status,
    output logic                         last
);
    import mm_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int FW    = $clog2(DEPTH + 1);
    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int IDX_W = $clog2(MAX_DIM);
    localparam int ACC_W = PROD_W + $clog2(MAX_DIM);
    localparam int FL_W  = $clog2(MAX_DIM + 2);

    typedef enum logic [2:0] {S_IDLE, S_STAT, S_ACC, S_FLUSH, S_UNLOAD} state_t;

    state_t                 state_reg;
    logic [DIM_REG_W-1:0]   a_rows_reg, a_cols_reg, b_rows_reg, b_cols_reg;
    logic [FW-1:0]          a_fill_reg, b_fill_reg;
    logic [IDX_W-1:0]       i_reg, k_reg, j_reg;
    logic [AW-1:0]          a_base_reg, a_addr_reg, b_addr_reg;
    logic [FL_W-1:0]        fl_reg;
    logic [STATUS_W-1:0]    st_code_reg;

    logic                   out_vld_reg;
    logic signed [ELEM_W-1:0] out_prod_reg;
    logic [POS_W-1:0]       out_row_reg, out_col_reg;
    logic [STATUS_W-1:0]    out_st_reg;
    logic                   out_last_reg;

    logic                   rd_vld_reg, p_vld_reg;
    logic [IDX_W-1:0]       rd_col_reg, p_col_reg;
    logic signed [PROD_W-1:0] p_val_reg;

    logic                   in_fire, out_free, unload_fire;
    logic                   a_wr, b_wr;
    logic [DIM_W-1:0]       ar, ac, bc;
    logic                   last_i, last_k, last_j;
    logic [ELEM_W-1:0]      a_rd, b_rd;
    cell_ctl_t              ctl;
    logic signed [ACC_W-1:0] head_sh;
    logic signed [ELEM_W-1:0] head_sat;

    logic                     tok_vld [MAX_DIM+1];
    logic [IDX_W-1:0]         tok_col [MAX_DIM+1];
    logic signed [PROD_W-1:0] tok_prod [MAX_DIM+1];
    logic signed [ACC_W-1:0]  acc [MAX_DIM+1];

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_rows_reg <= DIM_REG_W'(1);
            a_cols_reg <= DIM_REG_W'(1);
            b_rows_reg <= DIM_REG_W'(1);
            b_cols_reg <= DIM_REG_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_A_ROWS: a_rows_reg <= cfg_data;
                REG_A_COLS: a_cols_reg <= cfg_data;
                REG_B_ROWS: b_rows_reg <= cfg_data;
                REG_B_COLS: b_cols_reg <= cfg_data;
                default:    a_rows_reg <= a_rows_reg;
            endcase
        end
    end

    assign ar = (32'(a_rows_reg) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(a_rows_reg);
    assign ac = (32'(a_cols_reg) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(a_cols_reg);
    assign bc = (32'(b_cols_reg) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(b_cols_reg);

    assign last_i = (DIM_W'(i_reg) + DIM_W'(1)) == ar;
    assign last_k = (DIM_W'(k_reg) + DIM_W'(1)) == ac;
    assign last_j = (DIM_W'(j_reg) + DIM_W'(1)) == bc;

    assign in_stall    = (state_reg != S_IDLE);
    assign in_fire     = in_valid && !in_stall;
    assign out_free    = !out_vld_reg || !out_stall;
    assign unload_fire = (state_reg == S_UNLOAD) && out_free;

    assign a_wr = in_fire && (op == OP_LOAD_A) && (a_fill_reg < FW'(DEPTH));
    assign b_wr = in_fire && (op == OP_LOAD_B) && (b_fill_reg < FW'(DEPTH));

    mm_store #(.DEPTH(DEPTH), .AW(AW)) u_a_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (a_wr),
        .wr_addr (a_fill_reg[AW-1:0]),
        .wr_data (value),
        .rd_addr (a_addr_reg),
        .rd_data (a_rd)
    );

    mm_store #(.DEPTH(DEPTH), .AW(AW)) u_b_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (b_wr),
        .wr_addr (b_fill_reg[AW-1:0]),
        .wr_data (value),
        .rd_addr (b_addr_reg),
        .rd_data (b_rd)
    );

    // Read and multiply stages feeding the head of the chain.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
            p_vld_reg  <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= (state_reg == S_ACC);
            p_vld_reg  <= rd_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_col_reg <= j_reg;
        p_col_reg  <= rd_col_reg;
        p_val_reg  <= $signed(a_rd) * $signed(b_rd);
    end

    assign ctl.shift = unload_fire;
    assign ctl.clear = (in_fire && (op == OP_COMPUTE)) || (unload_fire && last_j);

    assign tok_vld[0]     = p_vld_reg;
    assign tok_col[0]     = p_col_reg;
    assign tok_prod[0]    = p_val_reg;
    assign acc[MAX_DIM]   = '0;

    for (genvar c = 0; c < MAX_DIM; c++)
    begin : g_cell
        mm_cell #(.ID(c), .IDX_W(IDX_W), .ACC_W(ACC_W)) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .tok_vld_i  (tok_vld[c]),
            .tok_col_i  (tok_col[c]),
            .tok_prod_i (tok_prod[c]),
            .tok_vld_o  (tok_vld[c+1]),
            .tok_col_o  (tok_col[c+1]),
            .tok_prod_o (tok_prod[c+1]),
            .acc_i      (acc[c+1]),
            .acc_o      (acc[c])
        );
    end

    // Drop the fraction bits (rounds toward minus infinity), then saturate.
    assign head_sh = acc[0] >>> FRAC_BITS;

    always_comb
    begin
        if ((&head_sh[ACC_W-1:ELEM_W-1]) || !(|head_sh[ACC_W-1:ELEM_W-1]))
        begin
            head_sat = head_sh[ELEM_W-1:0];
        end
        else if (head_sh[ACC_W-1])
        begin
            head_sat = {1'b1, {(ELEM_W-1){1'b0}}};
        end
        else
        begin
            head_sat = {1'b0, {(ELEM_W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            a_fill_reg  <= '0;
            b_fill_reg  <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (!out_stall)
            begin
                out_vld_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (a_wr)
                    begin
                        a_fill_reg <= a_fill_reg + FW'(1);
                    end
                    if (b_wr)
                    begin
                        b_fill_reg <= b_fill_reg + FW'(1);
                    end
                    if (in_fire && (op == OP_COMPUTE))
                    begin
                        a_fill_reg <= '0;
                        b_fill_reg <= '0;
                        i_reg      <= '0;
                        k_reg      <= '0;
                        j_reg      <= '0;
                        a_base_reg <= '0;
                        a_addr_reg <= '0;
                        b_addr_reg <= '0;
                        if ((a_rows_reg == '0) || (a_cols_reg == '0) ||
                            (b_rows_reg == '0) || (b_cols_reg == '0))
                        begin
                            st_code_reg <= ST_EMPTY;
                            state_reg   <= S_STAT;
                        end
                        else if (a_cols_reg != b_rows_reg)
                        begin
                            st_code_reg <= ST_MISMATCH;
                            state_reg   <= S_STAT;
                        end
                        else
                        begin
                            state_reg <= S_ACC;
                        end
                    end
                end
                S_STAT:
                begin
                    if (out_free)
                    begin
                        out_vld_reg  <= 1'b1;
                        out_prod_reg <= '0;
                        out_row_reg  <= '0;
                        out_col_reg  <= '0;
                        out_st_reg   <= st_code_reg;
                        out_last_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                S_ACC:
                begin
                    // Walk k outer, j inner so B is read in stored order.
                    b_addr_reg <= b_addr_reg + AW'(1);
                    if (last_j)
                    begin
                        j_reg <= '0;
                        if (last_k)
                        begin
                            fl_reg    <= '0;
                            state_reg <= S_FLUSH;
                        end
                        else
                        begin
                            k_reg      <= k_reg + IDX_W'(1);
                            a_addr_reg <= a_addr_reg + AW'(1);
                        end
                    end
                    else
                    begin
                        j_reg <= j_reg + IDX_W'(1);
                    end
                end
                S_FLUSH:
                begin
                    // Wait until the last product has reached the far end of the chain.
                    fl_reg <= fl_reg + FL_W'(1);
                    if (fl_reg == FL_W'(MAX_DIM + 1))
                    begin
                        j_reg     <= '0;
                        state_reg <= S_UNLOAD;
                    end
                end
                S_UNLOAD:
                begin
                    if (out_free)
                    begin
                        out_vld_reg  <= 1'b1;
                        out_prod_reg <= head_sat;
                        out_row_reg  <= POS_W'(i_reg);
                        out_col_reg  <= POS_W'(j_reg);
                        out_st_reg   <= ST_OK;
                        out_last_reg <= last_i && last_j;
                        if (last_j)
                        begin
                            j_reg <= '0;
                            if (last_i)
                            begin
                                state_reg <= S_IDLE;
                            end
                            else
                            begin
                                i_reg      <= i_reg + IDX_W'(1);
                                k_reg      <= '0;
                                a_base_reg <= a_base_reg + AW'(ac);
                                a_addr_reg <= a_base_reg + AW'(ac);
                                b_addr_reg <= '0;
                                state_reg  <= S_ACC;
                            end
                        end
                        else
                        begin
                            j_reg <= j_reg + IDX_W'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_vld_reg;
    assign product   = out_prod_reg;
    assign row_index = out_row_reg;
    assign col_index = out_col_reg;
    assign status    = out_st_reg;
    assign last      = out_last_reg;

    `MM_ASSERT_IMPLY(a_no_shift_in_flight, ctl.shift, !rd_vld_reg && !p_vld_reg, "accumulators shifted while products were in flight")
    `MM_ASSERT_IMPLY(a_status_alone, out_valid && (status != ST_OK), last && (product == '0), "error status result not single and zero")
    `MM_ASSERT_IMPLY(a_col_in_range, state_reg == S_ACC, DIM_W'(j_reg) < bc, "column counter beyond matrix width")

endmodule

### rtl/core/mm_store.sv
module mm_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [mm_pkg::ELEM_W-1:0] wr_data,
    input  logic [AW-1:0]             rd_addr,
    output logic [mm_pkg::ELEM_W-1:0] rd_data
);
    import mm_pkg::*;

    logic [ELEM_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  vld_reg;
    logic [ELEM_W-1:0] rd_data_reg;

    // A word never written since reset reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr_en)
        begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= vld_reg[rd_addr] ? mem[rd_addr] : '0;
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/mm_cell.sv
module mm_cell #(
    parameter int ID    = 0,
    parameter int IDX_W = 3,
    parameter int ACC_W = 67
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  mm_pkg::cell_ctl_t                ctl,
    input  logic                             tok_vld_i,
    input  logic [IDX_W-1:0]                 tok_col_i,
    input  logic signed [mm_pkg::PROD_W-1:0] tok_prod_i,
    output logic                             tok_vld_o,
    output logic [IDX_W-1:0]                 tok_col_o,
    output logic signed [mm_pkg::PROD_W-1:0] tok_prod_o,
    input  logic signed [ACC_W-1:0]          acc_i,
    output logic signed [ACC_W-1:0]          acc_o
);
    import mm_pkg::*;

    logic                     tok_vld_reg;
    logic [IDX_W-1:0]         tok_col_reg;
    logic signed [PROD_W-1:0] tok_prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_vld_reg <= 1'b0;
        end
        else
        begin
            tok_vld_reg <= tok_vld_i;
        end
    end

    // Products pass along the chain; only the cell owning the column adds.
    always_ff @(posedge clk)
    begin
        tok_col_reg  <= tok_col_i;
        tok_prod_reg <= tok_prod_i;
        if (ctl.clear)
        begin
            acc_reg <= '0;
        end
        else if (ctl.shift)
        begin
            acc_reg <= acc_i;
        end
        else if (tok_vld_i && (tok_col_i == IDX_W'(ID)))
        begin
            acc_reg <= acc_reg + ACC_W'(tok_prod_i);
        end
    end

    assign tok_vld_o  = tok_vld_reg;
    assign tok_col_o  = tok_col_reg;
    assign tok_prod_o = tok_prod_reg;
    assign acc_o      = acc_reg;

endmodule
